FILE: hdl/pgcrle_pkg.sv
// pgcrle_pkg: shared types and constants for the run-length screen image decoder
// widths, mode and status codes, one-hot phase encoding, result struct
// no dependencies
`timescale 1ns / 1ps

package pgcrle_pkg;

  localparam int unsigned IMAGE_BYTES_DEF = 1920;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned OFFSET_W = 11;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HDR_W    = 3;
  localparam int unsigned SKIP_W   = 16;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // register index of the mode register
  localparam logic [PADDR_W-3:0] REG_MODE = '0;
  localparam logic [MODE_W-1:0]  MODE_RESET = 2'd1;

  // container modes; the remaining code behaves as raw
  localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PGC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PGX = 2'd2;

  // signature and record bytes
  localparam logic [BYTE_W-1:0] SIG_P       = 8'h50;
  localparam logic [BYTE_W-1:0] SIG_G       = 8'h47;
  localparam logic [BYTE_W-1:0] SIG_X       = 8'h58;
  localparam logic [BYTE_W-1:0] SIG_VER     = 8'h01;
  localparam logic [BYTE_W-1:0] REC_NONE    = 8'hFF;
  localparam logic [BYTE_W-1:0] REC_IMAGE   = 8'h00;

  localparam logic [HDR_W-1:0] SIG_LEN      = 3'd3;
  localparam logic [HDR_W-1:0] HDR_LAST     = 3'd7;
  localparam logic [HDR_W-1:0] REC_TYPE_IDX = 3'd0;
  localparam logic [HDR_W-1:0] REC_LO_IDX   = 3'd1;
  localparam logic [HDR_W-1:0] REC_HI_IDX   = 3'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIG   = 3'd1,
    ST_NO_IMAGE  = 3'd2,
    ST_EARLY_END = 3'd3,
    ST_CLIPPED   = 3'd4,
    ST_RAW_LONG  = 3'd5
  } status_e;

  typedef enum logic [7:0] {
    PH_SIG  = 8'b0000_0001,
    PH_HDR  = 8'b0000_0010,
    PH_REC  = 8'b0000_0100,
    PH_SKIP = 8'b0000_1000,
    PH_CTRL = 8'b0001_0000,
    PH_LIT  = 8'b0010_0000,
    PH_RUN  = 8'b0100_0000,
    PH_DONE = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [COUNT_W-1:0]  repeat_count;
    logic [OFFSET_W-1:0] out_offset;
    logic                image_done;
    status_e             status;
  } result_t;

endpackage

FILE: hdl/pgc_rle_image_decoder_top.sv
// a byte is held in the input register, and its result is held in the result register
// throughput: one byte per cycle; a byte that yields a result waits only for a free result register
// bytes that yield no result never stall on the output side
// reset: asynchronous active-low; mode returns to compressed, decoder to signature check
// top level of the run-length screen image decoder
// depends on pgcrle_pkg, pgcrle_apb, pgcrle_core
`timescale 1ns / 1ps

module pgc_rle_image_decoder_top #(
  parameter int unsigned IMAGE_BYTES = pgcrle_pkg::IMAGE_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgcrle_pkg::PADDR_W-1:0]  paddr,
  input  logic [pgcrle_pkg::PDATA_W-1:0]  pwdata,
  output logic [pgcrle_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pgcrle_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pgcrle_pkg::BYTE_W-1:0]   out_byte_o,
  output logic [pgcrle_pkg::COUNT_W-1:0]  repeat_count_o,
  output logic [pgcrle_pkg::OFFSET_W-1:0] out_offset_o,
  output logic                            image_done_o,
  output logic [pgcrle_pkg::STATUS_W-1:0] status_o
);
  import pgcrle_pkg::*;

  logic [MODE_W-1:0] mode;
  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              in_xfer, advance, out_free, emit;
  result_t           res, res_q;
  logic              out_valid_q, out_valid_d;

  pgcrle_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  pgcrle_core #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .in_byte_i (in_byte_q),
    .last_i    (in_last_q),
    .mode_i    (mode),
    .emit_o    (emit),
    .res_o     (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!emit || out_free);
  assign in_ready_o = !in_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_byte_i;
      in_last_q <= last_byte_i;
    end
    if (advance && emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = res_q.out_byte;
  assign repeat_count_o = res_q.repeat_count;
  assign out_offset_o   = res_q.out_offset;
  assign image_done_o   = res_q.image_done;
  assign status_o       = res_q.status;

  // a result must never overwrite one still waiting for its transfer
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && emit && out_valid_q && !out_ready_i))
    else $error("result register overwritten while stalled");

  // a reported span stays inside the image
  a_span_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_offset_o} + {{(OFFSET_W+1-COUNT_W){1'b0}}, repeat_count_o})
      <= (OFFSET_W+1)'(IMAGE_BYTES))
    else $error("result span exceeds image");

  // any non-ok status ends the image
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit && (res.status != ST_OK)) |=> (out_valid_o && image_done_o))
    else $error("error status without image_done");

endmodule

FILE: hdl/pgcrle_apb.sv
// pgcrle_apb: apb-style configuration register (container mode)
// depends on pgcrle_pkg
`timescale 1ns / 1ps

module pgcrle_apb (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pgcrle_pkg::PADDR_W-1:0]  paddr,
  input  logic [pgcrle_pkg::PDATA_W-1:0]  pwdata,
  output logic [pgcrle_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [pgcrle_pkg::MODE_W-1:0]   mode_o
);
  import pgcrle_pkg::*;

  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [PADDR_W-3:0]   reg_idx;
  logic                 wr_en;

  // byte-lane bits of the address are ignored
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready & (reg_idx == REG_MODE);

  always_comb begin
    mode_d = mode_q;
    if (wr_en) begin
      mode_d = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODE) begin
      prdata = {{(PDATA_W-MODE_W){1'b0}}, mode_q};
    end
  end

  assign mode_o = mode_q;

endmodule

FILE: hdl/pgcrle_core.sv
// pgcrle_core: decoder state registers and the per-byte step logic
// signature check, container walk, run/literal decode, early-end handling
// depends on pgcrle_pkg
`timescale 1ns / 1ps

module pgcrle_core #(
  parameter int unsigned IMAGE_BYTES = pgcrle_pkg::IMAGE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  logic [pgcrle_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic                           last_i,
  input  logic [pgcrle_pkg::MODE_W-1:0]  mode_i,
  output logic                           emit_o,
  output pgcrle_pkg::result_t            res_o
);
  import pgcrle_pkg::*;

  localparam logic [OFFSET_W-1:0] IMG = OFFSET_W'(IMAGE_BYTES);

  phase_e              phase_q, phase_d;
  logic [HDR_W-1:0]    hc_q, hc_d;
  logic [COUNT_W-1:0]  lit_q, lit_d;
  logic [COUNT_W-1:0]  run_q, run_d;
  logic [OFFSET_W-1:0] pos_q, pos_d;
  logic [SKIP_W-1:0]   skip_q, skip_d;
  logic [BYTE_W-1:0]   len_lo_q, len_lo_d;
  logic                rec_img_q, rec_img_d;

  logic                raw, was_done, done, emit;
  status_e             st;
  logic [BYTE_W-1:0]   ob;
  logic [COUNT_W-1:0]  rc;
  logic [OFFSET_W-1:0] off;
  logic [OFFSET_W-1:0] rem, cnt, pos_inc, pos_run;
  logic [OFFSET_W-1:0] run_ext;
  logic [HDR_W-1:0]    hc_inc;
  logic [BYTE_W-1:0]   want;
  logic [SKIP_W-1:0]   skip_dec;
  logic [COUNT_W-1:0]  lit_dec;
  logic                clip;

  assign raw      = !((mode_i == MODE_PGC) || (mode_i == MODE_PGX));
  assign was_done = (phase_q == PH_DONE);
  // out position never exceeds the image size, so no wrap here
  assign rem      = IMG - pos_q;
  assign run_ext  = OFFSET_W'(run_q);
  assign clip     = (run_ext > rem);
  assign cnt      = clip ? rem : run_ext;
  assign pos_inc  = pos_q + OFFSET_W'(1);
  assign pos_run  = pos_q + cnt;
  assign hc_inc   = hc_q + HDR_W'(1);
  assign skip_dec = skip_q - SKIP_W'(skip_q != '0);
  assign lit_dec  = lit_q - COUNT_W'(lit_q != '0);

  always_comb begin
    priority if (hc_q == REC_TYPE_IDX) begin
      want = SIG_P;
    end else if (hc_q == REC_LO_IDX) begin
      want = SIG_G;
    end else if (mode_i == MODE_PGX) begin
      want = SIG_X;
    end else begin
      want = SIG_VER;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    hc_d      = hc_q;
    lit_d     = lit_q;
    run_d     = run_q;
    pos_d     = pos_q;
    skip_d    = skip_q;
    len_lo_d  = len_lo_q;
    rec_img_d = rec_img_q;
    emit      = 1'b0;
    ob        = '0;
    rc        = '0;
    off       = '0;
    st        = ST_OK;
    done      = 1'b0;

    if (was_done) begin
      // ignore bytes until re-armed
    end else if (raw) begin
      if (pos_q < IMG) begin
        emit  = 1'b1;
        ob    = in_byte_i;
        rc    = COUNT_W'(1);
        off   = pos_q;
        pos_d = pos_inc;
        if ((pos_inc >= IMG) && last_i) begin
          done = 1'b1;
        end
      end else begin
        emit = 1'b1;
        st   = ST_RAW_LONG;
        done = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PH_SIG: begin
          if (in_byte_i != want) begin
            emit = 1'b1;
            st   = ST_BAD_SIG;
            done = 1'b1;
          end else begin
            hc_d = hc_inc;
            if (hc_inc >= SIG_LEN) begin
              if (mode_i == MODE_PGX) begin
                phase_d = PH_HDR;
              end else begin
                phase_d = PH_CTRL;
                hc_d    = '0;
              end
            end
          end
        end
        PH_HDR: begin
          if (hc_q == HDR_LAST) begin
            phase_d = PH_REC;
            hc_d    = '0;
          end else begin
            hc_d = hc_inc;
          end
        end
        PH_REC: begin
          if ((hc_q == REC_TYPE_IDX) && (in_byte_i == REC_NONE)) begin
            emit = 1'b1;
            st   = ST_NO_IMAGE;
            done = 1'b1;
          end else begin
            if (hc_q == REC_TYPE_IDX) begin
              rec_img_d = (in_byte_i == REC_IMAGE);
            end
            if (hc_q == REC_LO_IDX) begin
              len_lo_d = in_byte_i;
            end
            if (hc_q == REC_HI_IDX) begin
              skip_d = {in_byte_i, len_lo_q};
            end
            if (hc_q == HDR_LAST) begin
              hc_d = '0;
              if (rec_img_q) begin
                phase_d = PH_CTRL;
                pos_d   = '0;
              end else if (skip_q != '0) begin
                phase_d = PH_SKIP;
              end
            end else begin
              hc_d = hc_inc;
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PH_REC;
            hc_d    = '0;
          end
        end
        PH_CTRL: begin
          if (in_byte_i[BYTE_W-1]) begin
            run_d   = in_byte_i[COUNT_W-1:0];
            phase_d = PH_RUN;
          end else if (in_byte_i != '0) begin
            lit_d   = in_byte_i[COUNT_W-1:0];
            phase_d = PH_LIT;
          end
        end
        PH_RUN: begin
          phase_d = PH_CTRL;
          // a zero-length run swallows its data byte silently
          if (run_q != '0) begin
            emit = 1'b1;
            if (clip) begin
              st   = ST_CLIPPED;
              done = 1'b1;
            end
            if (cnt != '0) begin
              ob  = in_byte_i;
              rc  = cnt[COUNT_W-1:0];
              off = pos_q;
            end
            pos_d = pos_run;
            if (pos_run >= IMG) begin
              done = 1'b1;
            end
          end
        end
        PH_LIT: begin
          emit = 1'b1;
          if (pos_q >= IMG) begin
            st   = ST_CLIPPED;
            done = 1'b1;
          end else begin
            ob    = in_byte_i;
            rc    = COUNT_W'(1);
            off   = pos_q;
            pos_d = pos_inc;
            lit_d = lit_dec;
            if (pos_inc >= IMG) begin
              done = 1'b1;
              if (lit_dec != '0) begin
                st = ST_CLIPPED;
              end
            end else if (lit_dec == '0) begin
              phase_d = PH_CTRL;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end

    if (done) begin
      phase_d = PH_DONE;
    end

    if (last_i) begin
      if (!was_done && !done) begin
        if (!raw && ((phase_d == PH_HDR) || (phase_d == PH_REC) || (phase_d == PH_SKIP))) begin
          st = ST_NO_IMAGE;
        end else begin
          st = ST_EARLY_END;
        end
        emit = 1'b1;
        done = 1'b1;
      end
      phase_d   = PH_SIG;
      hc_d      = '0;
      lit_d     = '0;
      run_d     = '0;
      pos_d     = '0;
      skip_d    = '0;
      len_lo_d  = '0;
      rec_img_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SIG;
      hc_q      <= '0;
      lit_q     <= '0;
      run_q     <= '0;
      pos_q     <= '0;
      skip_q    <= '0;
      len_lo_q  <= '0;
      rec_img_q <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      hc_q      <= hc_d;
      lit_q     <= lit_d;
      run_q     <= run_d;
      pos_q     <= pos_d;
      skip_q    <= skip_d;
      len_lo_q  <= len_lo_d;
      rec_img_q <= rec_img_d;
    end
  end

  assign emit_o             = emit;
  assign res_o.out_byte     = ob;
  assign res_o.repeat_count = rc;
  assign res_o.out_offset   = off;
  assign res_o.image_done   = done;
  assign res_o.status       = st;

endmodule
